[design/lis_pkg.sv]
// Shared constants, types and state codes for the longest increasing subsequence block.
// No dependencies; every other design file except lis_tails_ram imports this package.
`default_nettype none
package lis_pkg;

  localparam int MAX_ITEMS = 1024;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int VAL_W     = 32;
  localparam int OUT_W     = 11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE,
    ST_UPDATE,
    ST_REPORT
  } lis_state_e;

  typedef struct packed {
    logic [OUT_W-1:0] lis_length;
    logic [OUT_W-1:0] min_moves;
    logic             sequence_end;
    logic             overflow;
  } lis_res_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;
  } lis_ram_req_t;

endpackage
`default_nettype wire

[design/lis_if.sv]
// Valid/ready channel interfaces: input values and per-item results.
// Depends on lis_pkg for field widths.
`default_nettype none
interface lis_in_if import lis_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic                    last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface lis_out_if import lis_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] lis_length;
  logic [OUT_W-1:0] min_moves;
  logic             sequence_end;
  logic             overflow;

  modport source (output valid, output lis_length, output min_moves,
                  output sequence_end, output overflow, input ready);
  modport sink   (input valid, input lis_length, input min_moves,
                  input sequence_end, input overflow, output ready);
endinterface
`default_nettype wire

[design/lis_tails_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the tails table; no package dependency.
`default_nettype none
module lis_tails_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

[design/lis_seq.sv]
// Sequencer and shared compare unit: binary search over the tails RAM, then update.
// Depends on lis_pkg; drives lis_tails_ram through an lis_ram_req_t.
`default_nettype none
module lis_seq import lis_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [VAL_W-1:0]   value_i,
  input  wire logic               last_i,
  output lis_ram_req_t            ram_req_o,
  input  wire logic [VAL_W-1:0]   ram_rdata_i,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output lis_res_t                res_o
);

  lis_state_e       state_q, state_d;
  logic [VAL_W-1:0] key_q;
  logic             last_q;
  logic [CNT_W-1:0] lo_q, hi_q;
  logic [IDX_W-1:0] mid_q;
  logic [CNT_W-1:0] tail_cnt_q, item_cnt_q;
  logic             drop_q;
  logic [CNT_W-1:0] mid_full;
  logic             accept;
  logic             full;
  logic             key_above;

  assign accept    = in_valid_i && in_ready_o;
  assign full      = (item_cnt_q == CNT_W'(MAX_ITEMS));
  assign mid_full  = lo_q + ((hi_q - lo_q) >> 1);
  // Keys carry a flipped sign bit, so unsigned order equals signed order.
  assign key_above = key_q > ram_rdata_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = full ? ST_REPORT : ST_PROBE;
      ST_PROBE:   state_d = (lo_q < hi_q) ? ST_COMPARE : ST_UPDATE;
      ST_COMPARE: state_d = ST_PROBE;
      ST_UPDATE:  state_d = ST_REPORT;
      ST_REPORT:  if (res_ready_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o        = 1'b0;
    res_valid_o       = 1'b0;
    ram_req_o         = '0;
    ram_req_o.rd_addr = mid_full[IDX_W-1:0];
    ram_req_o.wr_addr = lo_q[IDX_W-1:0];
    ram_req_o.wr_data = key_q;
    case (state_q)
      ST_IDLE:   in_ready_o        = 1'b1;
      ST_PROBE:  ram_req_o.rd_en   = (lo_q < hi_q);
      ST_UPDATE: ram_req_o.wr_en   = 1'b1;
      ST_REPORT: res_valid_o       = 1'b1;
      default:   in_ready_o        = 1'b0;
    endcase
  end

  always_comb begin
    res_o.lis_length   = OUT_W'(tail_cnt_q);
    res_o.min_moves    = OUT_W'(item_cnt_q - tail_cnt_q);
    res_o.sequence_end = last_q;
    res_o.overflow     = drop_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      tail_cnt_q <= '0;
      item_cnt_q <= '0;
      drop_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (accept && full) drop_q <= 1'b1;
        end
        ST_UPDATE: begin
          item_cnt_q <= item_cnt_q + 1'b1;
          // Append when the slot is one past the last tail.
          if (lo_q == tail_cnt_q) tail_cnt_q <= tail_cnt_q + 1'b1;
        end
        ST_REPORT: begin
          if (res_ready_i && last_q) begin
            tail_cnt_q <= '0;
            item_cnt_q <= '0;
            drop_q     <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_q  <= {~value_i[VAL_W-1], value_i[VAL_W-2:0]};
          last_q <= last_i;
          lo_q   <= '0;
          hi_q   <= tail_cnt_q;
        end
      end
      ST_PROBE:   mid_q <= mid_full[IDX_W-1:0];
      ST_COMPARE: begin
        if (key_above) lo_q <= CNT_W'(mid_q) + 1'b1;
        else           hi_q <= CNT_W'(mid_q);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[design/longest_increasing_subsequence.sv]
// Top level: search sequencer, tails RAM and the result output register.
// Depends on lis_pkg, lis_if, lis_tails_ram and lis_seq.
//
//   channel  dir  payload                                        handshake
//   req_i    in   value (s32), last                              valid/ready
//   rsp_o    out  lis_length, min_moves, sequence_end, overflow  valid/ready
//
// Each item makes P probes, at most ceil(log2(tail count + 1)); the binary search does
// one RAM read and one compare per probe, then writes the tails RAM and reports.
// A dropped item (capacity reached) skips the search and goes straight to the report.
// Reset clears counts and flags only; the tails RAM is not cleared.
// The result register frees the search: a new request is taken while a result waits,
// and the sequencer holds its next result until the register is free.
`default_nettype none
module longest_increasing_subsequence import lis_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lis_in_if.sink      req_i,
  lis_out_if.source   rsp_o
);

  lis_ram_req_t     ram_req;
  logic [VAL_W-1:0] ram_rdata;
  logic             res_valid;
  logic             res_free;
  lis_res_t         res;
  logic             out_valid_q;
  lis_res_t         out_q;

  assign res_free = !out_valid_q || rsp_o.ready;

  lis_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .value_i     (req_i.value),
    .last_i      (req_i.last),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_free),
    .res_o       (res)
  );

  lis_tails_ram #(
    .DEPTH (MAX_ITEMS),
    .WIDTH (VAL_W)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (ram_req.rd_en),
    .rd_addr_i (ram_req.rd_addr),
    .rd_data_o (ram_rdata),
    .wr_en_i   (ram_req.wr_en),
    .wr_addr_i (ram_req.wr_addr),
    .wr_data_i (ram_req.wr_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.lis_length   = out_q.lis_length;
  assign rsp_o.min_moves    = out_q.min_moves;
  assign rsp_o.sequence_end = out_q.sequence_end;
  assign rsp_o.overflow     = out_q.overflow;

endmodule
`default_nettype wire

[design/lis_checker.sv]
// Port-level checks for longest_increasing_subsequence, attached by bind.
// Depends on lis_pkg for widths and capacity.
`default_nettype none
module lis_checker import lis_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [OUT_W-1:0] lis_length,
  input wire logic [OUT_W-1:0] min_moves,
  input wire logic             sequence_end,
  input wire logic             overflow
);

  logic [OUT_W:0] total;
  assign total = {1'b0, lis_length} + {1'b0, min_moves};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(lis_length) && $stable(min_moves)
      && $stable(sequence_end) && $stable(overflow))
    else $error("stalled result changed");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one still in work");

  a_length_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> lis_length != '0)
    else $error("result with empty subsequence");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && overflow |-> total == (OUT_W+1)'(MAX_ITEMS))
    else $error("overflow reported below capacity");

endmodule

bind longest_increasing_subsequence lis_checker u_lis_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (req_i.valid),
  .in_ready     (req_i.ready),
  .out_valid    (rsp_o.valid),
  .out_ready    (rsp_o.ready),
  .lis_length   (rsp_o.lis_length),
  .min_moves    (rsp_o.min_moves),
  .sequence_end (rsp_o.sequence_end),
  .overflow     (rsp_o.overflow)
);
`default_nettype wire
